// ----- src/cda_pkg.sv -----
// shared constants, types and calendar helpers for the date adder
package cda_pkg;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned OUTCOME_W = 2;

  // working widths: year may run past the field before saturation, day sum up to 61
  localparam int unsigned YACC_W = 15;
  localparam int unsigned DACC_W = 6;

  localparam int unsigned YEAR_MAX       = 9999;
  localparam int unsigned YEAR_FIELD_MAX = 16383;
  localparam int unsigned YEAR_LIMIT     = (YEAR_MAX < YEAR_FIELD_MAX) ? YEAR_MAX : YEAR_FIELD_MAX;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_OK       = 2'd0,
    OUTCOME_INVALID  = 2'd1,
    OUTCOME_OVERFLOW = 2'd2
  } outcome_e;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0]   DAY_LEAP = 5'd29;
  localparam logic [COUNT_W-1:0] YEAR_SKIP_MIN  = 16'd365;
  localparam logic [COUNT_W-1:0] MONTH_SKIP_MIN = 16'd30;
  localparam logic [8:0]         YEAR_LEN_COMMON = 9'd365;
  localparam logic [8:0]         YEAR_LEN_LEAP   = 9'd366;

  // residue counters for the century rules
  localparam logic [6:0] R100_LAST = 7'd99;
  localparam logic [8:0] R400_LAST = 9'd399;

  // restoring reduction of the start year: six steps give mod 400, two more give mod 100
  localparam int unsigned PREP_STEPS = 8;
  localparam logic [2:0]  PREP_R400_STEP = 3'd5;
  localparam logic [2:0]  PREP_LAST      = 3'd7;
  localparam logic [YEAR_W-1:0] PREP_DIV [PREP_STEPS] = '{
    14'd12800, 14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400, 14'd200, 14'd100
  };

  typedef struct packed {
    logic load;
    logic prep_step;
    logic check;
    logic year_step;
    logic month_step;
    logic add_days;
    logic day_step;
    logic finish;
  } cda_cmd_t;

  typedef struct packed {
    logic prep_last;
    logic invalid;
    logic year_more;
    logic month_more;
    logic day_more;
  } cda_status_t;

  function automatic logic leap_year(input logic [1:0] y_lo, input logic [6:0] r100,
                                     input logic [8:0] r400);
    return ((y_lo == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- src/cda_in_if.sv -----
// input channel: start date and day count
interface cda_in_if
  import cda_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   start_day;
  logic [MONTH_W-1:0] start_month;
  logic [YEAR_W-1:0]  start_year;
  logic [COUNT_W-1:0] day_count;

  modport source (output valid, start_day, start_month, start_year, day_count, input ready);
  modport sink   (input valid, start_day, start_month, start_year, day_count, output ready);
endinterface

// ----- src/cda_out_if.sv -----
// output channel: resulting date and outcome
interface cda_out_if
  import cda_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     end_day;
  logic [MONTH_W-1:0]   end_month;
  logic [YEAR_W-1:0]    end_year;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, end_day, end_month, end_year, outcome, input ready);
  modport sink   (input valid, end_day, end_month, end_year, outcome, output ready);
endinterface

// ----- src/calendar_date_add_days.sv -----
// top level of the gregorian date adder
//
// usage
// - in_i carries one word: start day, month, year and a count of days to add
// - out_o returns one word per input: end day, month, year and an outcome code
//   (ok, invalid start date, or year overflow with the year held at the limit)
// - both channels use valid/ready; a word moves when both are high at a clock edge
// throughput and sequence
// - one word at a time; in_i.ready is high only while the sequencer is idle
// - after acceptance: the prep steps reduce the start year to its mod-400 and
//   mod-100 residues, the check state tests the date, then the walk skips whole
//   years (at most 179), then whole months (at most 12), adds the remaining
//   days, rolls over each month that the days overflow (at most 2), and loads
//   the result in the done state
// - an invalid start date skips the walk and goes from the check to done
// - the walk steps one year or one month per cycle
// reset
// - rst_ni clears the sequencer to idle and drops out_o.valid; no clearing pass
// stalls
// - a finished word sits in the result register until taken; the next input
//   word is accepted meanwhile, and its result waits in the done state
module calendar_date_add_days
  import cda_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  cda_in_if.sink    in_i,
  cda_out_if.source out_o
);

  cda_cmd_t    cmd;
  cda_status_t status;

  // sequencer: one state per phase of the year/month/day walk
  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // working date, remaining count, leap residues and result register
  cda_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_day_i   (in_i.start_day),
    .start_month_i (in_i.start_month),
    .start_year_i  (in_i.start_year),
    .day_count_i   (in_i.day_count),
    .end_day_o     (out_o.end_day),
    .end_month_o   (out_o.end_month),
    .end_year_o    (out_o.end_year),
    .outcome_o     (out_o.outcome)
  );

endmodule

// ----- src/cda_datapath.sv -----
// date adder datapath: working registers, residue counters and result register
module cda_datapath
  import cda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cda_cmd_t             cmd_i,
  output cda_status_t          status_o,
  input  logic [DAY_W-1:0]     start_day_i,
  input  logic [MONTH_W-1:0]   start_month_i,
  input  logic [YEAR_W-1:0]    start_year_i,
  input  logic [COUNT_W-1:0]   day_count_i,
  output logic [DAY_W-1:0]     end_day_o,
  output logic [MONTH_W-1:0]   end_month_o,
  output logic [YEAR_W-1:0]    end_year_o,
  output logic [OUTCOME_W-1:0] outcome_o
);

  logic [DACC_W-1:0]    d_q, d_d;
  logic [MONTH_W-1:0]   m_q, m_d;
  logic [YACC_W-1:0]    y_q, y_d;
  logic [COUNT_W-1:0]   n_q, n_d;
  logic [6:0]           r100_q, r100_d;
  logic [8:0]           r400_q, r400_d;
  logic [YEAR_W-1:0]    rem_q, rem_d;
  logic [2:0]           step_q, step_d;
  logic                 invalid_q, invalid_d;
  logic [DAY_W-1:0]     end_day_q;
  logic [MONTH_W-1:0]   end_month_q;
  logic [YEAR_W-1:0]    end_year_q;
  logic [OUTCOME_W-1:0] outcome_q;

  logic                 leap_cur, leap_next, early, over;
  logic [DAY_W-1:0]     mlen;
  logic [8:0]           ylen;
  logic [YEAR_W-1:0]    rem_red;
  logic [YACC_W-1:0]    y_inc;
  logic [6:0]           r100_inc;
  logic [8:0]           r400_inc;

  assign leap_cur  = leap_year(y_q[1:0], r100_q, r400_q);
  // y+1 is leap when y ends in 3 mod 4 and y+1 is no plain century, or y+1 hits 400
  assign leap_next = ((y_q[1:0] == 2'd3) && (r100_q != R100_LAST)) || (r400_q == R400_LAST);
  assign mlen      = month_len(m_q, leap_cur);
  assign early     = (m_q <= MONTH_FEB);
  assign ylen      = (early ? leap_cur : leap_next) ? YEAR_LEN_LEAP : YEAR_LEN_COMMON;
  assign y_inc     = y_q + YACC_W'(1);
  assign r100_inc  = (r100_q == R100_LAST) ? 7'd0 : r100_q + 7'd1;
  assign r400_inc  = (r400_q == R400_LAST) ? 9'd0 : r400_q + 9'd1;
  assign rem_red   = (rem_q >= PREP_DIV[step_q]) ? rem_q - PREP_DIV[step_q] : rem_q;
  assign over      = (y_q > YACC_W'(YEAR_LIMIT));

  assign status_o.prep_last  = (step_q == PREP_LAST);
  assign status_o.invalid    = (d_q == '0) || (d_q > DACC_W'(mlen));
  assign status_o.year_more  = (n_q > YEAR_SKIP_MIN);
  assign status_o.month_more = (n_q > MONTH_SKIP_MIN);
  assign status_o.day_more   = (d_q > DACC_W'(mlen));

  always_comb begin
    d_d       = d_q;
    m_d       = m_q;
    y_d       = y_q;
    n_d       = n_q;
    r100_d    = r100_q;
    r400_d    = r400_q;
    rem_d     = rem_q;
    step_d    = step_q;
    invalid_d = invalid_q;
    if (cmd_i.load) begin
      d_d    = DACC_W'(start_day_i);
      m_d    = start_month_i;
      y_d    = YACC_W'(start_year_i);
      n_d    = day_count_i;
      rem_d  = start_year_i;
      step_d = '0;
    end
    if (cmd_i.prep_step) begin
      rem_d  = rem_red;
      step_d = step_q + 3'd1;
      if (step_q == PREP_R400_STEP) begin
        r400_d = rem_red[8:0];
      end
      if (step_q == PREP_LAST) begin
        r100_d = rem_red[6:0];
      end
    end
    if (cmd_i.check) begin
      invalid_d = status_o.invalid;
      // leap day with a nonzero count steps onto the first of march
      if (!status_o.invalid && (n_q != '0) && (m_q == MONTH_FEB)
          && (d_q == DACC_W'(DAY_LEAP))) begin
        m_d = MONTH_MAR;
        d_d = DACC_W'(1);
        n_d = n_q - COUNT_W'(1);
      end
    end
    if (cmd_i.year_step) begin
      n_d    = n_q - COUNT_W'(ylen);
      y_d    = y_inc;
      r100_d = r100_inc;
      r400_d = r400_inc;
    end
    if (cmd_i.add_days) begin
      d_d = d_q + DACC_W'(n_q);
    end
    if (cmd_i.month_step || cmd_i.day_step) begin
      if (cmd_i.month_step) begin
        n_d = n_q - COUNT_W'(mlen);
      end else begin
        d_d = d_q - DACC_W'(mlen);
      end
      if (m_q == MONTH_DEC) begin
        m_d    = MONTH_JAN;
        y_d    = y_inc;
        r100_d = r100_inc;
        r400_d = r400_inc;
      end else begin
        m_d = m_q + MONTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q         <= '0;
      m_q         <= '0;
      y_q         <= '0;
      n_q         <= '0;
      r100_q      <= '0;
      r400_q      <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      invalid_q   <= 1'b0;
      end_day_q   <= '0;
      end_month_q <= '0;
      end_year_q  <= '0;
      outcome_q   <= OUTCOME_OK;
    end else begin
      d_q       <= d_d;
      m_q       <= m_d;
      y_q       <= y_d;
      n_q       <= n_d;
      r100_q    <= r100_d;
      r400_q    <= r400_d;
      rem_q     <= rem_d;
      step_q    <= step_d;
      invalid_q <= invalid_d;
      if (cmd_i.finish) begin
        end_day_q   <= d_q[DAY_W-1:0];
        end_month_q <= m_q;
        if (invalid_q) begin
          end_year_q <= y_q[YEAR_W-1:0];
          outcome_q  <= OUTCOME_INVALID;
        end else if (over) begin
          end_year_q <= YEAR_W'(YEAR_LIMIT);
          outcome_q  <= OUTCOME_OVERFLOW;
        end else begin
          end_year_q <= y_q[YEAR_W-1:0];
          outcome_q  <= OUTCOME_OK;
        end
      end
    end
  end

  assign end_day_o   = end_day_q;
  assign end_month_o = end_month_q;
  assign end_year_o  = end_year_q;
  assign outcome_o   = outcome_q;

endmodule

// ----- src/cda_ctrl.sv -----
// date adder controller: sequencing state machine and result valid flag
module cda_ctrl
  import cda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  cda_status_t status_i,
  output cda_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_YEARS  = 7'b0001000,
    ST_MONTHS = 7'b0010000,
    ST_DAYS   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } cda_state_e;

  cda_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep_step = 1'b1;
        if (status_i.prep_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.invalid ? ST_DONE : ST_YEARS;
      end
      ST_YEARS: begin
        if (status_i.year_more) begin
          cmd_o.year_step = 1'b1;
        end else begin
          state_d = ST_MONTHS;
        end
      end
      ST_MONTHS: begin
        if (status_i.month_more) begin
          cmd_o.month_step = 1'b1;
        end else begin
          cmd_o.add_days = 1'b1;
          state_d        = ST_DAYS;
        end
      end
      ST_DAYS: begin
        if (status_i.day_more) begin
          cmd_o.day_step = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait only while the result register still holds an untaken word
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
